### sv/vtp_pkg.sv
// Shared types, constants and helpers for the vertex to pixel projection block.
// No dependencies; used by the front, back and top modules and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package vtp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_DIM_DEF   = 4096;

    localparam int COEF_W = 32;
    localparam int DIM_W  = 13;
    localparam int PIX_W  = 12;
    localparam int TOL_W  = 4;
    localparam int QUO_W  = 14;
    localparam int CRD_W  = QUO_W + 2;

    localparam logic [63:0] ROW0_XY_RST = 64'h0000_0000_0001_0000;
    localparam logic [63:0] ROW0_ZT_RST = 64'h0;
    localparam logic [63:0] ROW1_XY_RST = 64'h0001_0000_0000_0000;
    localparam logic [63:0] ROW1_ZT_RST = 64'h0;
    localparam logic [63:0] ROW3_XY_RST = 64'h0;
    localparam logic [63:0] ROW3_ZT_RST = 64'h0001_0000_0000_0000;
    localparam logic [DIM_W-1:0] DIM_RST = 13'd512;

    typedef enum logic [2:0] {
        REG_ROW0_XY,
        REG_ROW0_ZT,
        REG_ROW1_XY,
        REG_ROW1_ZT,
        REG_ROW3_XY,
        REG_ROW3_ZT,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } vtp_reg_t;

    typedef struct packed {
        logic [63:0]      row0_xy;
        logic [63:0]      row0_zt;
        logic [63:0]      row1_xy;
        logic [63:0]      row1_zt;
        logic [63:0]      row3_xy;
        logic [63:0]      row3_zt;
        logic [DIM_W-1:0] width_eff;
        logic [DIM_W-1:0] height_eff;
    } vtp_cfg_t;

    typedef struct packed {
        logic             neg_x;
        logic             neg_y;
        logic             w_zero;
        logic [TOL_W-1:0] tol;
    } vtp_flags_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                                 input int max_dim);
        if (int'(raw) > max_dim)
            return DIM_W'(max_dim);
        return raw;
    endfunction

    function automatic logic signed [CRD_W-1:0] snap_coord(
        input logic signed [CRD_W-1:0] c,
        input logic [DIM_W-1:0]        dim,
        input logic [TOL_W-1:0]        tol
    );
        logic signed [CRD_W-1:0] dimc;
        logic signed [CRD_W-1:0] tolc;
        dimc = signed'({{(CRD_W-DIM_W){1'b0}}, dim});
        tolc = signed'({{(CRD_W-TOL_W){1'b0}}, tol});
        if (c < 0 && -c < tolc)
            return '0;
        if (c >= dimc && c - dimc + 1 < tolc)
            return dimc - 1;
        return c;
    endfunction

    function automatic logic coord_inside(input logic signed [CRD_W-1:0] c,
                                          input logic [DIM_W-1:0]        dim);
        logic signed [CRD_W-1:0] dimc;
        dimc = signed'({{(CRD_W-DIM_W){1'b0}}, dim});
        return (c >= 0) && (c <= dimc - 1);
    endfunction

endpackage

`default_nettype wire

### sv/vtp_fifo.sv
// Small register queue with push/full and pop/empty handshakes.
// No dependencies; used between the front and back halves and at the result side.
`timescale 1ns / 1ps
`default_nettype none

module vtp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

### sv/vtp_front.sv
// Front half: matrix rows times vertex, homogeneous sums, sign/magnitude split
// and scaling by the image size. Depends on vtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vtp_front #(
    parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF,
    localparam int SUM_W = 66 - FRAC_BITS,
    localparam int NUM_W = SUM_W + 1,
    localparam int DIV_W = vtp_pkg::DIM_W + NUM_W
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire vtp_pkg::vtp_cfg_t           cfg,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic signed [31:0]          vert_x,
    input  wire logic signed [31:0]          vert_y,
    input  wire logic signed [31:0]          vert_z,
    input  wire logic [vtp_pkg::TOL_W-1:0]   snap_tolerance,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [DIV_W-1:0]                 out_nx,
    output logic [DIV_W-1:0]                 out_ny,
    output logic [NUM_W-1:0]                 out_ud,
    output vtp_pkg::vtp_flags_t              out_flags
);

    import vtp_pkg::*;

    logic [63:0]              xy [3];
    logic [63:0]              zt [3];
    logic signed [31:0]       coef [3][3];
    logic signed [31:0]       trans [3];

    logic                     a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic                     en;

    logic signed [63:0]       prod_reg [3][3];
    logic [TOL_W-1:0]         a_tol_reg;

    logic signed [63:0]       shifted [3][3];
    logic signed [SUM_W-1:0]  sum_next [3];
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic [TOL_W-1:0]         b_tol_reg;

    logic signed [NUM_W-1:0]  nx, ny, dd;
    logic [NUM_W-1:0]         ux_reg, uy_reg, ud_c_reg;
    vtp_flags_t               c_flags_reg;

    logic [DIV_W-1:0]         nx_reg, ny_reg;
    logic [NUM_W-1:0]         ud_d_reg;
    vtp_flags_t               d_flags_reg;

    always_comb
    begin
        xy[0] = cfg.row0_xy;
        xy[1] = cfg.row1_xy;
        xy[2] = cfg.row3_xy;
        zt[0] = cfg.row0_zt;
        zt[1] = cfg.row1_zt;
        zt[2] = cfg.row3_zt;
        for (int r = 0; r < 3; r++)
        begin
            coef[r][0] = xy[r][31:0];
            coef[r][1] = xy[r][63:32];
            coef[r][2] = zt[r][31:0];
            trans[r]   = zt[r][63:32];
        end
    end

    assign en        = !(d_valid_reg && !out_ready);
    assign full      = !en;
    assign out_valid = d_valid_reg;
    assign out_nx    = nx_reg;
    assign out_ny    = ny_reg;
    assign out_ud    = ud_d_reg;
    assign out_flags = d_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= push;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // floor to the integer grid, then exact sum with the translation word
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int j = 0; j < 3; j++)
                shifted[r][j] = prod_reg[r][j] >>> FRAC_BITS;
            sum_next[r] = shifted[r][0][SUM_W-1:0] + shifted[r][1][SUM_W-1:0]
                        + shifted[r][2][SUM_W-1:0]
                        + {{(SUM_W-COEF_W){trans[r][31]}}, trans[r]};
        end
    end

    always_comb
    begin
        nx = {sum_reg[0][SUM_W-1], sum_reg[0]} + {sum_reg[2][SUM_W-1], sum_reg[2]};
        ny = {sum_reg[1][SUM_W-1], sum_reg[1]} + {sum_reg[2][SUM_W-1], sum_reg[2]};
        dd = {sum_reg[2], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[r][0] <= coef[r][0] * vert_x;
                prod_reg[r][1] <= coef[r][1] * vert_y;
                prod_reg[r][2] <= coef[r][2] * vert_z;
                sum_reg[r]     <= sum_next[r];
            end
            a_tol_reg <= snap_tolerance;
            b_tol_reg <= a_tol_reg;

            ux_reg   <= nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
            uy_reg   <= ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
            ud_c_reg <= dd[NUM_W-1] ? NUM_W'(-dd) : NUM_W'(dd);
            c_flags_reg.neg_x  <= nx[NUM_W-1] ^ dd[NUM_W-1];
            c_flags_reg.neg_y  <= ny[NUM_W-1] ^ dd[NUM_W-1];
            c_flags_reg.w_zero <= (sum_reg[2] == '0);
            c_flags_reg.tol    <= b_tol_reg;

            nx_reg      <= DIV_W'(cfg.width_eff) * DIV_W'(ux_reg);
            ny_reg      <= DIV_W'(cfg.height_eff) * DIV_W'(uy_reg);
            ud_d_reg    <= ud_c_reg;
            d_flags_reg <= c_flags_reg;
        end
    end

endmodule

`default_nettype wire

### sv/vtp_back.sv
// Back half: pipelined restoring division (one quotient bit per stage),
// sign restore, row flip, border snap and bounds test. Depends on vtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vtp_back #(
    parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF,
    localparam int SUM_W = 66 - FRAC_BITS,
    localparam int NUM_W = SUM_W + 1,
    localparam int DIV_W = vtp_pkg::DIM_W + NUM_W
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire vtp_pkg::vtp_cfg_t           cfg,
    input  wire logic                        in_valid,
    output logic                             in_pop,
    input  wire logic [DIV_W-1:0]            in_nx,
    input  wire logic [DIV_W-1:0]            in_ny,
    input  wire logic [NUM_W-1:0]            in_ud,
    input  wire vtp_pkg::vtp_flags_t         in_flags,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [vtp_pkg::PIX_W-1:0]        out_col,
    output logic [vtp_pkg::PIX_W-1:0]        out_row,
    output logic                             out_inside
);

    import vtp_pkg::*;

    localparam int REM_W = NUM_W + QUO_W;
    localparam int NST   = QUO_W + 1;

    logic                    valid_reg [NST];
    logic [REM_W-1:0]        remx_reg [NST], remx_next [NST];
    logic [REM_W-1:0]        remy_reg [NST], remy_next [NST];
    logic [QUO_W-1:0]        qx_reg [NST], qx_next [NST];
    logic [QUO_W-1:0]        qy_reg [NST], qy_next [NST];
    logic                    ovx_reg [NST], ovx_next [NST];
    logic                    ovy_reg [NST], ovy_next [NST];
    logic [NUM_W-1:0]        ud_reg [NST], ud_next [NST];
    vtp_flags_t              flags_reg [NST], flags_next [NST];

    logic [REM_W-1:0]        dsh;
    logic                    gex, gey;
    logic                    en;

    logic [QUO_W-1:0]        mx, my;
    logic signed [CRD_W-1:0] col_raw, row_raw, col_s, row_s;
    logic signed [CRD_W-1:0] mxs, mys, hs;
    logic                    ok;
    vtp_flags_t              fl;

    assign en        = !(valid_reg[NST-1] && !out_ready);
    assign in_pop    = en && in_valid;
    assign out_valid = valid_reg[NST-1];

    always_comb
    begin
        remx_next[0]  = REM_W'(in_nx);
        remy_next[0]  = REM_W'(in_ny);
        dsh           = {in_ud, {QUO_W{1'b0}}};
        ovx_next[0]   = remx_next[0] >= dsh;
        ovy_next[0]   = remy_next[0] >= dsh;
        qx_next[0]    = '0;
        qy_next[0]    = '0;
        ud_next[0]    = in_ud;
        flags_next[0] = in_flags;
        for (int s = 1; s < NST; s++)
        begin
            dsh = REM_W'(ud_reg[s-1]) << (QUO_W - s);
            gex = remx_reg[s-1] >= dsh;
            gey = remy_reg[s-1] >= dsh;
            remx_next[s] = gex ? remx_reg[s-1] - dsh : remx_reg[s-1];
            remy_next[s] = gey ? remy_reg[s-1] - dsh : remy_reg[s-1];
            qx_next[s]   = qx_reg[s-1];
            qy_next[s]   = qy_reg[s-1];
            qx_next[s][QUO_W-s] = gex;
            qy_next[s][QUO_W-s] = gey;
            ovx_next[s]   = ovx_reg[s-1];
            ovy_next[s]   = ovy_reg[s-1];
            ud_next[s]    = ud_reg[s-1];
            flags_next[s] = flags_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
                valid_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NST; s++)
            begin
                remx_reg[s]  <= remx_next[s];
                remy_reg[s]  <= remy_next[s];
                qx_reg[s]    <= qx_next[s];
                qy_reg[s]    <= qy_next[s];
                ovx_reg[s]   <= ovx_next[s];
                ovy_reg[s]   <= ovy_next[s];
                ud_reg[s]    <= ud_next[s];
                flags_reg[s] <= flags_next[s];
            end
        end
    end

    // saturated quotients are far outside the image and always cull
    always_comb
    begin
        fl      = flags_reg[NST-1];
        mx      = ovx_reg[NST-1] ? '1 : qx_reg[NST-1];
        my      = ovy_reg[NST-1] ? '1 : qy_reg[NST-1];
        mxs     = signed'({2'b00, mx});
        mys     = signed'({2'b00, my});
        hs      = signed'({{(CRD_W-DIM_W){1'b0}}, cfg.height_eff});
        col_raw = fl.neg_x ? -mxs : mxs;
        row_raw = fl.neg_y ? hs + mys : hs - mys;
        col_s   = snap_coord(col_raw, cfg.width_eff, fl.tol);
        row_s   = snap_coord(row_raw, cfg.height_eff, fl.tol);
        ok      = !fl.w_zero && coord_inside(col_s, cfg.width_eff)
                  && coord_inside(row_s, cfg.height_eff);
        out_col    = ok ? col_s[PIX_W-1:0] : '0;
        out_row    = ok ? row_s[PIX_W-1:0] : '0;
        out_inside = ok;
    end

endmodule

`default_nettype wire

### sv/vertex_to_pixel_projection.sv
// Top level of the vertex to pixel projection block: APB register file,
// front and back halves joined by a queue, result queue. Depends on vtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Projects one Q16.16 vertex per clock to a pixel column and row of the
// configured image, with border snap and a culled flag. Throughput is one
// vertex per cycle while full is low; a result passes 21 registers: four
// front stages (products, sums, magnitudes, image scaling), the middle queue,
// fifteen divider stages (a range check, then one quotient bit each) and the
// result queue. Matrix rows and image size sit at 8-byte strides on the APB
// port and may only be changed while no vertex is in flight.
module vertex_to_pixel_projection #(
    parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF,
    parameter int MAX_DIM   = vtp_pkg::MAX_DIM_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [5:0]                  paddr,
    input  wire logic [63:0]                 pwdata,
    output logic      [63:0]                 prdata,
    output logic                             pready,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic signed [31:0]          vert_x,
    input  wire logic signed [31:0]          vert_y,
    input  wire logic signed [31:0]          vert_z,
    input  wire logic [vtp_pkg::TOL_W-1:0]   snap_tolerance,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [vtp_pkg::PIX_W-1:0]        pixel_col,
    output logic [vtp_pkg::PIX_W-1:0]        pixel_row,
    output logic                             inside_res
);

    import vtp_pkg::*;

    localparam int SUM_W  = 66 - FRAC_BITS;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DIV_W  = DIM_W + NUM_W;
    localparam int FLG_W  = $bits(vtp_flags_t);
    localparam int MID_W  = 2 * DIV_W + NUM_W + FLG_W;
    localparam int RES_W  = 2 * PIX_W + 1;

    logic [63:0]      row0_xy_reg, row0_zt_reg, row1_xy_reg, row1_zt_reg;
    logic [63:0]      row3_xy_reg, row3_zt_reg;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic             wr_en;
    vtp_reg_t         reg_sel;
    vtp_cfg_t         cfg;

    logic             f_valid, f_ready;
    logic [DIV_W-1:0] f_nx, f_ny;
    logic [NUM_W-1:0] f_ud;
    vtp_flags_t       f_flags;

    logic             mid_full, mid_empty, mid_pop;
    logic [MID_W-1:0] mid_wdata, mid_rdata;
    logic [DIV_W-1:0] b_nx, b_ny;
    logic [NUM_W-1:0] b_ud;
    vtp_flags_t       b_flags;

    logic             r_valid, r_full;
    logic [PIX_W-1:0] r_col, r_row;
    logic             r_inside;
    logic [RES_W-1:0] res_rdata;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = vtp_reg_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_xy_reg <= ROW0_XY_RST;
            row0_zt_reg <= ROW0_ZT_RST;
            row1_xy_reg <= ROW1_XY_RST;
            row1_zt_reg <= ROW1_ZT_RST;
            row3_xy_reg <= ROW3_XY_RST;
            row3_zt_reg <= ROW3_ZT_RST;
            width_reg   <= DIM_RST;
            height_reg  <= DIM_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ROW0_XY:      row0_xy_reg <= pwdata;
                REG_ROW0_ZT:      row0_zt_reg <= pwdata;
                REG_ROW1_XY:      row1_xy_reg <= pwdata;
                REG_ROW1_ZT:      row1_zt_reg <= pwdata;
                REG_ROW3_XY:      row3_xy_reg <= pwdata;
                REG_ROW3_ZT:      row3_zt_reg <= pwdata;
                REG_IMAGE_WIDTH:  width_reg   <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= pwdata[DIM_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ROW0_XY:      prdata = row0_xy_reg;
            REG_ROW0_ZT:      prdata = row0_zt_reg;
            REG_ROW1_XY:      prdata = row1_xy_reg;
            REG_ROW1_ZT:      prdata = row1_zt_reg;
            REG_ROW3_XY:      prdata = row3_xy_reg;
            REG_ROW3_ZT:      prdata = row3_zt_reg;
            REG_IMAGE_WIDTH:  prdata = 64'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 64'(height_reg);
        endcase
    end

    always_comb
    begin
        cfg.row0_xy    = row0_xy_reg;
        cfg.row0_zt    = row0_zt_reg;
        cfg.row1_xy    = row1_xy_reg;
        cfg.row1_zt    = row1_zt_reg;
        cfg.row3_xy    = row3_xy_reg;
        cfg.row3_zt    = row3_zt_reg;
        cfg.width_eff  = eff_dim(width_reg, MAX_DIM);
        cfg.height_eff = eff_dim(height_reg, MAX_DIM);
    end

    vtp_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .push          (push),
        .full          (full),
        .vert_x        (vert_x),
        .vert_y        (vert_y),
        .vert_z        (vert_z),
        .snap_tolerance(snap_tolerance),
        .out_valid     (f_valid),
        .out_ready     (f_ready),
        .out_nx        (f_nx),
        .out_ny        (f_ny),
        .out_ud        (f_ud),
        .out_flags     (f_flags)
    );

    assign f_ready   = !mid_full;
    assign mid_wdata = {f_nx, f_ny, f_ud, f_flags};

    vtp_fifo #(
        .WIDTH(MID_W),
        .DEPTH(4)
    ) u_mid_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (f_valid),
        .full (mid_full),
        .wdata(mid_wdata),
        .pop  (mid_pop),
        .empty(mid_empty),
        .rdata(mid_rdata)
    );

    assign {b_nx, b_ny, b_ud, b_flags} = mid_rdata;

    vtp_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (!mid_empty),
        .in_pop    (mid_pop),
        .in_nx     (b_nx),
        .in_ny     (b_ny),
        .in_ud     (b_ud),
        .in_flags  (b_flags),
        .out_valid (r_valid),
        .out_ready (!r_full),
        .out_col   (r_col),
        .out_row   (r_row),
        .out_inside(r_inside)
    );

    vtp_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (r_valid),
        .full (r_full),
        .wdata({r_col, r_row, r_inside}),
        .pop  (pop),
        .empty(empty),
        .rdata(res_rdata)
    );

    assign {pixel_col, pixel_row, inside_res} = res_rdata;

    a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !inside_res |-> pixel_col == '0 && pixel_row == '0)
        else $error("culled result carries a nonzero pixel");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && inside_res |-> {1'b0, pixel_col} < cfg.width_eff)
        else $error("pixel column outside image");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && inside_res |-> {1'b0, pixel_row} < cfg.height_eff)
        else $error("pixel row outside image");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for vertex_to_pixel_projection: APB setup, vertex stream,
// result checking against an in-bench projection predictor. Depends on vtp_pkg.
`timescale 1ns / 1ps

module tb;
    import vtp_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic             in_image;
    } pixel_t;

    class proj_scoreboard;
        logic [63:0] regs [8];
        pixel_t      pending [$];
        int          errors;
        int          n_inside;
        int          n_culled;

        function new();
            regs[REG_ROW0_XY]      = ROW0_XY_RST;
            regs[REG_ROW0_ZT]      = ROW0_ZT_RST;
            regs[REG_ROW1_XY]      = ROW1_XY_RST;
            regs[REG_ROW1_ZT]      = ROW1_ZT_RST;
            regs[REG_ROW3_XY]      = ROW3_XY_RST;
            regs[REG_ROW3_ZT]      = ROW3_ZT_RST;
            regs[REG_IMAGE_WIDTH]  = 64'(DIM_RST);
            regs[REG_IMAGE_HEIGHT] = 64'(DIM_RST);
        endfunction

        function longint dot(logic [63:0] xy, logic [63:0] zt,
                             longint vx, longint vy, longint vz);
            longint a;
            longint b;
            longint c;
            a = (longint'($signed(xy[31:0])) * vx) >>> FRAC_BITS_DEF;
            b = (longint'($signed(xy[63:32])) * vy) >>> FRAC_BITS_DEF;
            c = (longint'($signed(zt[31:0])) * vz) >>> FRAC_BITS_DEF;
            return a + b + c + longint'($signed(zt[63:32]));
        endfunction

        // trunc(dim * num / den), quotient capped at 2^27
        function longint scaled_quot(longint num, longint den, longint dim);
            logic        neg;
            logic [63:0] un;
            logic [63:0] ud;
            logic [63:0] q;
            logic [63:0] r;
            logic [127:0] frac;
            longint      m;
            neg  = (num < 0) != (den < 0);
            un   = num < 0 ? -num : num;
            ud   = den < 0 ? -den : den;
            q    = un / ud;
            r    = un % ud;
            if (q > 64'd134217728)
                m = dim * 134217728;
            else
            begin
                frac = (128'(dim) * 128'(r)) / 128'(ud);
                m = dim * longint'(q) + longint'(frac[63:0]);
            end
            return neg ? -m : m;
        endfunction

        function longint snapped(longint c, longint dim, longint tol);
            if (c < 0 && -c < tol)
                return 0;
            if (c >= dim && c - dim + 1 < tol)
                return dim - 1;
            return c;
        endfunction

        function longint dim_of(logic [63:0] r);
            longint d;
            d = longint'(r[12:0]);
            return d > MAX_DIM_DEF ? MAX_DIM_DEF : d;
        endfunction

        function void note_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z, logic [TOL_W-1:0] tol);
            pixel_t p;
            longint w;
            longint h;
            longint pw;
            longint px;
            longint py;
            longint c;
            longint rw;
            p = '{col: '0, row: '0, in_image: 1'b0};
            w = dim_of(regs[REG_IMAGE_WIDTH]);
            h = dim_of(regs[REG_IMAGE_HEIGHT]);
            pw = dot(regs[REG_ROW3_XY], regs[REG_ROW3_ZT], x, y, z);
            if (pw != 0)
            begin
                px = dot(regs[REG_ROW0_XY], regs[REG_ROW0_ZT], x, y, z);
                py = dot(regs[REG_ROW1_XY], regs[REG_ROW1_ZT], x, y, z);
                c  = scaled_quot(px + pw, 2 * pw, w);
                rw = h - scaled_quot(py + pw, 2 * pw, h);
                c  = snapped(c, w, longint'(tol));
                rw = snapped(rw, h, longint'(tol));
                if (!(c < 0 || c > w - 1 || rw < 0 || rw > h - 1))
                    p = '{col: c[PIX_W-1:0], row: rw[PIX_W-1:0], in_image: 1'b1};
            end
            pending.insert(pending.size(), p);
        endfunction

        function void check_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                                  logic in_image);
            pixel_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result col=%0d row=%0d inside=%0b",
                         $time, col, row, in_image);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.in_image) n_inside++; else n_culled++;
            if (col !== e.col || row !== e.row || in_image !== e.in_image)
            begin
                $display("%0t: mismatch expected col=%0d row=%0d inside=%0b, %s%0d %s%0d %s%0b",
                         $time, e.col, e.row, e.in_image,
                         "got col=", col, "row=", row, "inside=", in_image);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [5:0]        paddr = '0;
    logic [63:0]       pwdata = '0;
    logic [63:0]       prdata;
    logic              pready;
    logic              push = 1'b0;
    logic              full;
    logic signed [31:0] vert_x = '0;
    logic signed [31:0] vert_y = '0;
    logic signed [31:0] vert_z = '0;
    logic [TOL_W-1:0]  snap_tolerance = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [PIX_W-1:0]  pixel_col;
    logic [PIX_W-1:0]  pixel_row;
    logic              inside_res;

    proj_scoreboard sb = new();
    bit  quiet = 1'b0;
    int  stall_left = 0;
    longint cycles = 0;

    vertex_to_pixel_projection u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full),
        .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
        .snap_tolerance(snap_tolerance),
        .empty(empty), .pop(pop),
        .pixel_col(pixel_col), .pixel_row(pixel_row), .inside_res(inside_res)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 300000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            pop <= 1'b0;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_pixel(pixel_col, pixel_row, inside_res);

    task automatic reg_write(vtp_reg_t idx, logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.regs[idx] = (idx >= REG_IMAGE_WIDTH) ? (val & 64'h1FFF) : val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic send_vertex(int x, int y, int z, int tol);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
        @(negedge clk);
        push           <= 1'b1;
        vert_x         <= x;
        vert_y         <= y;
        vert_z         <= z;
        snap_tolerance <= tol[TOL_W-1:0];
        do @(posedge clk); while (full);
        sb.note_vertex(x, y, z, tol[TOL_W-1:0]);
    endtask

    function automatic int rand_coord();
        int m;
        m = $urandom_range(0, 9);
        if (m < 2) return $urandom;
        if (m < 4) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        return $signed($urandom_range(0, 150000)) - 75000;
    endfunction

    function automatic logic [63:0] rand_pair(int span);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $signed($urandom_range(0, 2 * span)) - span;
        hi = $signed($urandom_range(0, 2 * span)) - span;
        return {hi, lo};
    endfunction

    task automatic random_vertices(int n);
        repeat (n)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 15));
    endtask

    task automatic random_matrix(int span, logic [63:0] w_zt);
        reg_write(REG_ROW0_XY, rand_pair(span));
        reg_write(REG_ROW0_ZT, rand_pair(span));
        reg_write(REG_ROW1_XY, rand_pair(span));
        reg_write(REG_ROW1_ZT, rand_pair(span));
        reg_write(REG_ROW3_XY, rand_pair(span / 8));
        reg_write(REG_ROW3_ZT, w_zt);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // identity setup, 512x512: borders, snap and field extremes
        send_vertex(0, 0, 0, 0);
        send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 15);
        send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 0);
        send_vertex(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 5);
        send_vertex(65536, 65536, 0, 0);
        send_vertex(65536, 65536, 0, 2);
        send_vertex(-65536, -65536, 0, 0);
        send_vertex(-65536, -65536, 0, 1);
        send_vertex(65536 + 300, -65536 - 300, 0, 15);
        send_vertex(65536 + 300, -65536 - 300, 0, 1);
        send_vertex(-65536 - 500, 65536 + 500, 0, 3);
        send_vertex(65535, -65535, 0, 0);
        random_vertices(100);
        drain();

        // perspective: w = z plus random x and y terms, with no translation
        random_matrix(131072, {32'h0, 32'h0001_0000});
        reg_write(REG_IMAGE_WIDTH, $urandom_range(2, 4096));
        reg_write(REG_IMAGE_HEIGHT, $urandom_range(2, 4096));
        send_vertex(1000, -1000, 0, 4);
        send_vertex(0, 0, 0, 15);
        send_vertex(65536, 65536, 1, 0);
        send_vertex(65536, 65536, -1, 0);
        repeat (100)
            send_vertex(rand_coord(), rand_coord(), $urandom_range(1, 400000),
                        $urandom_range(0, 15));
        drain();

        // full-range coefficients, smallest image
        reg_write(REG_ROW0_XY, {$urandom, $urandom});
        reg_write(REG_ROW0_ZT, {$urandom, $urandom});
        reg_write(REG_ROW1_XY, {$urandom, $urandom});
        reg_write(REG_ROW1_ZT, {$urandom, $urandom});
        reg_write(REG_ROW3_XY, {$urandom, $urandom});
        reg_write(REG_ROW3_ZT, {$urandom, $urandom});
        reg_write(REG_IMAGE_WIDTH, 2);
        reg_write(REG_IMAGE_HEIGHT, 2);
        random_vertices(100);
        drain();

        // largest image, near-identity
        random_matrix(8192, {32'h0001_0000, 32'h0});
        reg_write(REG_ROW0_XY, 64'h0000_0000_0001_0000);
        reg_write(REG_ROW1_XY, 64'h0001_0000_0000_0000);
        reg_write(REG_IMAGE_WIDTH, 4096);
        reg_write(REG_IMAGE_HEIGHT, 4096);
        send_vertex(65535, -65535, 0, 0);
        send_vertex(65536, -65536, 0, 2);
        random_vertices(100);
        drain();

        // oversized and degenerate image sizes
        reg_write(REG_IMAGE_WIDTH, 8191);
        reg_write(REG_IMAGE_HEIGHT, 1);
        random_vertices(60);
        drain();
        reg_write(REG_IMAGE_WIDTH, 0);
        reg_write(REG_IMAGE_HEIGHT, 5000);
        random_vertices(60);
        drain();

        // random setups, the last one without idling
        repeat (3)
        begin
            random_matrix(98304, {$signed($urandom_range(0, 262144)) - 131072,
                                  32'h0000_8000});
            reg_write(REG_IMAGE_WIDTH, $urandom_range(2, 4096));
            reg_write(REG_IMAGE_HEIGHT, $urandom_range(2, 4096));
            random_vertices(80);
            drain();
        end
        quiet = 1'b1;
        random_matrix(65536, {32'h0001_0000, 32'h0000_4000});
        random_vertices(120);
        drain();

        $display("Covered %0d in-image and %0d culled vertices over identity,",
                 sb.n_inside, sb.n_culled);
        $display("perspective, full-range, extreme and degenerate image setups.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
